FILE: rtl/dpd_pkg.sv
package dpd_pkg;

    localparam int unsigned QueueDepthDefault = 4;

    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_END   = 8'h23;
    localparam logic [7:0] CH_ESC   = 8'h7D;
    localparam logic [7:0] ESC_XOR  = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_UPF   = 8'h46;
    localparam logic [7:0] CH_LOWA  = 8'h61;
    localparam logic [7:0] CH_LOWF  = 8'h66;

    typedef enum logic [1:0] {
        EV_START = 2'd0,
        EV_BYTE  = 2'd1,
        EV_GOOD  = 2'd2,
        EV_BAD   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] payload;
        logic       ack;
    } t_event;

endpackage

FILE: rtl/dpd_front.sv
module dpd_front import dpd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_char,
    input  logic       i_accept,
    input  logic       i_ack_enabled,
    output logic       o_push,
    output t_event     o_event
);

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_DATA = 5'b00010,
        PH_ESC  = 5'b00100,
        PH_CK1  = 5'b01000,
        PH_CK2  = 5'b10000
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_exp, n_exp;
    logic       emit;
    logic       fail;
    logic [4:0] hex;
    logic [7:0] ck_full;

    function automatic logic [4:0] hex_decode(input logic [7:0] ch);
        logic [7:0] v;
        v = 8'd0;
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            v = ch - CH_ZERO;
            return {1'b1, v[3:0]};
        end else if (ch >= CH_UPA && ch <= CH_UPF) begin
            v = ch - CH_UPA + 8'd10;
            return {1'b1, v[3:0]};
        end else if (ch >= CH_LOWA && ch <= CH_LOWF) begin
            v = ch - CH_LOWA + 8'd10;
            return {1'b1, v[3:0]};
        end
        return 5'd0;
    endfunction

    assign hex     = hex_decode(i_char);
    assign ck_full = r_exp + {4'd0, hex[3:0]};

    always_comb begin
        n_phase = r_phase;
        n_sum   = r_sum;
        n_exp   = r_exp;
        emit    = 1'b0;
        fail    = 1'b0;
        o_event = '{kind: EV_START, payload: 8'd0, ack: 1'b0};
        if (i_char == CH_START) begin
            n_phase = PH_DATA;
            n_sum   = 8'd0;
            emit    = 1'b1;
        end else if (i_char == CH_END) begin
            if (r_phase == PH_DATA) begin
                n_phase = PH_CK1;
            end else begin
                fail = 1'b1;
            end
        end else if (i_char == CH_ESC) begin
            if (r_phase == PH_DATA) begin
                n_sum   = r_sum + i_char;
                n_phase = PH_ESC;
            end else begin
                fail = 1'b1;
            end
        end else begin
            unique case (r_phase)
                PH_DATA: begin
                    n_sum   = r_sum + i_char;
                    emit    = 1'b1;
                    o_event = '{kind: EV_BYTE, payload: i_char, ack: 1'b0};
                end
                PH_ESC: begin
                    n_sum   = r_sum + i_char;
                    n_phase = PH_DATA;
                    emit    = 1'b1;
                    o_event = '{kind: EV_BYTE, payload: i_char ^ ESC_XOR, ack: 1'b0};
                end
                PH_CK1: begin
                    if (hex[4]) begin
                        n_exp   = {hex[3:0], 4'd0};
                        n_phase = PH_CK2;
                    end else begin
                        fail = 1'b1;
                    end
                end
                PH_CK2: begin
                    if (hex[4]) begin
                        n_exp = ck_full;
                        if (ck_full == r_sum) begin
                            n_phase = PH_IDLE;
                            emit    = 1'b1;
                            o_event = '{kind: EV_GOOD, payload: 8'd0, ack: i_ack_enabled};
                        end else begin
                            fail = 1'b1;
                        end
                    end else begin
                        fail = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        if (fail && r_phase != PH_IDLE) begin
            n_phase = PH_IDLE;
            emit    = 1'b1;
            o_event = '{kind: EV_BAD, payload: 8'd0, ack: i_ack_enabled};
        end
    end

    assign o_push = i_valid && i_accept && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_sum   <= 8'd0;
            r_exp   <= 8'd0;
        end else if (i_valid && i_accept) begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_exp   <= n_exp;
        end
    end

endmodule

FILE: rtl/dpd_queue.sv
module dpd_queue import dpd_pkg::*; #(
    parameter int unsigned DEPTH = QueueDepthDefault
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_event i_event,
    output logic   o_full,
    output logic   o_valid,
    output t_event o_event,
    input  logic   i_pop
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    t_event            r_mem [DEPTH];
    logic [PtrW-1:0]   r_wr, r_rd;
    logic [CntW-1:0]   r_count;
    logic              do_pop;

    function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
        if (p == PtrW'(DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_event = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_next(r_wr);
            end
            if (do_pop) begin
                r_rd <= ptr_next(r_rd);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/debug_packet_deframer.sv
// Packet deframer for a serial debug stream of the form '$' payload '#' hh.
// One received character enters per request on the s_axis channel. Each
// character causes at most one event on the m_axis channel: packet start,
// an unescaped payload byte, packet good or packet bad. For good and bad
// events the ack bit tells the sender whether to answer with an ack character ('+' or '-').
// The cfg channel writes the one-bit ack enable; it is always ready and
// should only be written while no request is in flight.
// An accepted character's event is registered in the queue before it
// reaches the output. The parser takes one character every cycle; events
// wait in a small queue (QUEUE_DEPTH entries), so the input only stalls
// once the queue is full because the receiver holds m_axis_tready low.
// Reset returns the parser to idle, clears the checksum state and the
// queue, and sets the ack enable.
module debug_packet_deframer import dpd_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [8] send_ack_char
    output logic [1:0]  m_axis_tuser,   // [1:0] event_kind
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);

    logic   r_ack_enabled;
    logic   push;
    logic   full;
    t_event front_event;
    t_event head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_enabled <= 1'b1;
        end else if (i_cfg_valid) begin
            r_ack_enabled <= i_cfg_data;
        end
    end

    assign s_axis_tready = !full;

    dpd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .i_char        (s_axis_tdata),
        .i_accept      (s_axis_tready),
        .i_ack_enabled (r_ack_enabled),
        .o_push        (push),
        .o_event       (front_event)
    );

    dpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_event (front_event),
        .o_full  (full),
        .o_valid (m_axis_tvalid),
        .o_event (head),
        .i_pop   (m_axis_tready)
    );

    assign m_axis_tdata = {7'd0, head.ack, head.payload};
    assign m_axis_tuser = head.kind;

endmodule
